// ----- design/gvfm_pkg.sv -----
// Shared types, constants and helpers for the greedy voxel face mesher.
// No dependencies.
`default_nettype none
package gvfm_pkg;
  localparam int MaxEdge  = 8;
  localparam int Cells    = MaxEdge * MaxEdge;
  localparam int IdxW     = $clog2(Cells);
  localparam int CoordW   = $clog2(MaxEdge);
  localparam int KeyW     = 50;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMerge,
    CfgSize
  } cfg_idx_e;

  typedef struct packed {
    logic        renderable;
    logic        neighbor_occluding;
    logic [7:0]  material_id;
    logic [31:0] face_color;
    logic        transparent;
    logic [11:0] ao_occlusion;
    logic [2:0]  face;
    logic [2:0]  slice;
    logic        last_cell;
  } cell_t;

  typedef struct packed {
    logic [2:0]  quad_u;
    logic [2:0]  quad_v;
    logic [3:0]  quad_width;
    logic [3:0]  quad_height;
    logic [2:0]  out_face;
    logic [2:0]  out_slice;
    logic [7:0]  out_material;
    logic [31:0] out_color;
    logic        out_transparent;
    logic [7:0]  ao_levels;
    logic        flip_diagonal;
    logic        last_quad;
  } quad_t;

  typedef enum logic [3:0] {
    StIdle, StAnchor, StFind, StRight, StRightChk, StDown, StDownChk, StMark, StEmit,
    StFlush
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;        // store the accepted cell
    logic scan_init;   // scan position to (0,0)
    logic scan_next;   // advance scan position
    logic start_rect;  // latch anchor key, w=h=1
    logic rd_anchor;   // read cell at scan position
    logic rd_right;    // read cell right of the rectangle
    logic rd_down;     // read cell in the row under the rectangle
    logic grow_w;
    logic col_next;    // next column of the row under test
    logic grow_h;
    logic mark_init;
    logic mark_next;
    logic emit;        // rectangle done, hand it to the output buffer
    logic flush;       // scan done, release the held quad as last
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic anchor_live;
    logic scan_last;
    logic can_right;   // u+w < n
    logic can_down;    // v+h < n
    logic probe_match;
    logic col_last;
    logic mark_last;
    logic merge_en;
  } sts_t;

  function automatic logic [1:0] ao_level(input logic [2:0] b);
    if (b[0] && b[1]) return 2'd0;
    return 2'(2'd3 - 2'(b[0]) - 2'(b[1]) - 2'(b[2]));
  endfunction
endpackage
`default_nettype wire

// ----- design/gvfm_ctrl.sv -----
// Sequencer for load and greedy merge scan.
// Depends on gvfm_pkg.
`default_nettype none
module gvfm_ctrl import gvfm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic last_i,
  input  sts_t      sts_i,
  output ctl_t      ctl_o,
  output logic      busy_o
);
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    busy_o  = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          if (last_i) begin
            ctl_o.scan_init = 1'b1;
            state_d = StAnchor;
          end
        end
      end
      StAnchor: begin
        ctl_o.rd_anchor = 1'b1;
        state_d = StFind;
      end
      // anchor read data valid here
      StFind: begin
        if (sts_i.anchor_live) begin
          ctl_o.start_rect = 1'b1;
          if (sts_i.merge_en) begin
            state_d = StRight;
          end else begin
            ctl_o.mark_init = 1'b1;
            state_d = StMark;
          end
        end else if (sts_i.scan_last) begin
          state_d = StFlush;
        end else begin
          ctl_o.scan_next = 1'b1;
          state_d = StAnchor;
        end
      end
      StRight: begin
        if (sts_i.can_right) begin
          ctl_o.rd_right = 1'b1;
          state_d = StRightChk;
        end else begin
          state_d = StDown;
        end
      end
      StRightChk: begin
        if (sts_i.probe_match) begin
          ctl_o.grow_w = 1'b1;
          state_d = StRight;
        end else begin
          state_d = StDown;
        end
      end
      StDown: begin
        if (sts_i.can_down) begin
          ctl_o.rd_down = 1'b1;
          state_d = StDownChk;
        end else begin
          ctl_o.mark_init = 1'b1;
          state_d = StMark;
        end
      end
      StDownChk: begin
        if (!sts_i.probe_match) begin
          ctl_o.mark_init = 1'b1;
          state_d = StMark;
        end else if (sts_i.col_last) begin
          ctl_o.grow_h = 1'b1;
          state_d = StDown;
        end else begin
          ctl_o.col_next = 1'b1;
          state_d = StDown;
        end
      end
      StMark: begin
        ctl_o.mark_next = 1'b1;
        if (sts_i.mark_last) state_d = StEmit;
      end
      StEmit: begin
        ctl_o.emit = 1'b1;
        if (sts_i.scan_last) begin
          state_d = StFlush;
        end else begin
          ctl_o.scan_next = 1'b1;
          state_d = StAnchor;
        end
      end
      StFlush: begin
        ctl_o.flush = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

// ----- design/gvfm_dp.sv -----
// Datapath: key memory, consumed bits, scan/rectangle counters, quad build.
// Depends on gvfm_pkg.
`default_nettype none
module gvfm_dp import gvfm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  cell_t                    cell_i,
  input  ctl_t                     ctl_i,
  input  wire logic                cfg_we_i,
  input  cfg_idx_e                 cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  output sts_t                     sts_o,
  output quad_t                    quad_o,
  output logic                     quad_vld_o
);
  logic [KeyW-1:0]  mem_q [Cells];
  logic [KeyW-1:0]  rd_q;
  logic [KeyW-1:0]  k0_q;
  logic [Cells-1:0] cons_q;
  logic             cons_rd_q;
  logic             merge_q;
  logic [3:0]       size_q;
  logic [IdxW-1:0]  cnt_q;
  logic [5:0]       latch_q;
  logic [CoordW:0]  u_q, v_q, w_q, h_q, a_q, mb_q, ma_q;
  quad_t            hold_q;
  logic             have_q;
  quad_t            quad_q;
  logic             qv_q;

  logic [CoordW:0] n;
  logic [IdxW:0]   cells, idx_inc;
  logic [IdxW-1:0] idx, rd_addr, mk_addr;
  logic            rd_en;
  logic [7:0]      lv;
  logic [KeyW-1:0] key;
  quad_t           quad_new;

  // row-major cell address, row*n + col
  function automatic logic [IdxW-1:0] cell_addr(input logic [CoordW:0] col,
                                                input logic [CoordW:0] row,
                                                input logic [CoordW:0] size_n);
    logic [2*CoordW+1:0] p;
    p = {{(CoordW+1){1'b0}}, row} * {{(CoordW+1){1'b0}}, size_n} +
        {{(CoordW+1){1'b0}}, col};
    return p[IdxW-1:0];
  endfunction

  always_comb begin
    if (size_q == 4'd0)                n = 4'd1;
    else if (size_q > 4'(MaxEdge))     n = 4'(MaxEdge);
    else                               n = size_q;
    cells   = {{(IdxW-CoordW){1'b0}}, n} * {{(IdxW-CoordW){1'b0}}, n};
    idx     = ({1'b0, cnt_q} >= cells) ? '0 : cnt_q;
    idx_inc = {1'b0, idx} + 1'b1;
    for (int k = 0; k < 4; k++) lv[2*k +: 2] = ao_level(cell_i.ao_occlusion[3*k +: 3]);
    key = '0;
    if (cell_i.renderable && !cell_i.neighbor_occluding)
      key = {lv, cell_i.transparent, cell_i.face_color, cell_i.material_id, 1'b1};
    // single read port: anchor, right probe or probe in the row below
    rd_en = ctl_i.rd_anchor || ctl_i.rd_right || ctl_i.rd_down;
    if (ctl_i.rd_right)     rd_addr = cell_addr(u_q + w_q, v_q, n);
    else if (ctl_i.rd_down) rd_addr = cell_addr(u_q + a_q, v_q + h_q, n);
    else                    rd_addr = cell_addr(u_q, v_q, n);
    mk_addr = cell_addr(u_q + ma_q, v_q + mb_q, n);
  end

  always_comb begin
    quad_new.quad_u          = u_q[CoordW-1:0];
    quad_new.quad_v          = v_q[CoordW-1:0];
    quad_new.quad_width      = w_q;
    quad_new.quad_height     = h_q;
    quad_new.out_face        = latch_q[2:0];
    quad_new.out_slice       = latch_q[5:3];
    quad_new.out_material    = k0_q[8:1];
    quad_new.out_color       = k0_q[40:9];
    quad_new.out_transparent = k0_q[41];
    quad_new.ao_levels       = k0_q[49:42];
    quad_new.flip_diagonal   = ({1'b0, k0_q[43:42]} + {1'b0, k0_q[47:46]}) >
                               ({1'b0, k0_q[45:44]} + {1'b0, k0_q[49:48]});
    quad_new.last_quad       = 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) mem_q[idx] <= key;
    if (rd_en) rd_q <= mem_q[rd_addr];
    if (ctl_i.start_rect) k0_q <= rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cons_q <= '0; cons_rd_q <= 1'b0; merge_q <= 1'b1; size_q <= 4'd8;
      cnt_q <= '0; latch_q <= '0; u_q <= '0; v_q <= '0; w_q <= '0; h_q <= '0;
      a_q <= '0; mb_q <= '0; ma_q <= '0; have_q <= 1'b0; qv_q <= 1'b0;
      hold_q <= '0; quad_q <= '0;
    end else begin
      qv_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgMerge: merge_q <= cfg_data_i[0];
          CfgSize:  size_q  <= cfg_data_i;
        endcase
      end
      if (rd_en) cons_rd_q <= cons_q[rd_addr];
      if (ctl_i.load) begin
        cons_q[idx] <= 1'b0;
        if (idx == '0) latch_q <= {cell_i.slice, cell_i.face};
        cnt_q <= (cell_i.last_cell || idx_inc >= cells) ? '0 : idx_inc[IdxW-1:0];
      end
      if (ctl_i.scan_init) begin
        u_q <= '0; v_q <= '0;
      end
      if (ctl_i.scan_next) begin
        if (u_q + 1'b1 >= n) begin u_q <= '0; v_q <= v_q + 1'b1; end
        else u_q <= u_q + 1'b1;
      end
      if (ctl_i.start_rect) begin
        w_q <= 4'd1; h_q <= 4'd1; a_q <= '0;
      end
      if (ctl_i.grow_w) w_q <= w_q + 1'b1;
      if (ctl_i.col_next) a_q <= a_q + 1'b1;
      if (ctl_i.grow_h) begin h_q <= h_q + 1'b1; a_q <= '0; end
      if (ctl_i.mark_init) begin mb_q <= '0; ma_q <= '0; end
      if (ctl_i.mark_next) begin
        cons_q[mk_addr] <= 1'b1;
        if (ma_q + 1'b1 >= w_q) begin ma_q <= '0; mb_q <= mb_q + 1'b1; end
        else ma_q <= ma_q + 1'b1;
      end
      // one quad is held back so the final one can carry last_quad
      if (ctl_i.emit) begin
        hold_q <= quad_new;
        have_q <= 1'b1;
        if (have_q) begin
          quad_q <= hold_q;
          qv_q   <= 1'b1;
        end
      end
      if (ctl_i.flush && have_q) begin
        quad_q           <= hold_q;
        quad_q.last_quad <= 1'b1;
        qv_q             <= 1'b1;
        have_q           <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.anchor_live = rd_q[0] && !cons_rd_q;
    sts_o.scan_last   = (u_q + 1'b1 >= n) && (v_q + 1'b1 >= n);
    sts_o.can_right   = (u_q + w_q < n);
    sts_o.can_down    = (v_q + h_q < n);
    sts_o.probe_match = rd_q[0] && !cons_rd_q && (rd_q == k0_q);
    sts_o.col_last    = (a_q + 1'b1 >= w_q);
    sts_o.mark_last   = (mb_q + 1'b1 >= h_q) && (ma_q + 1'b1 >= w_q);
    sts_o.merge_en    = merge_q;
  end

  assign quad_o = quad_q;
  assign quad_vld_o = qv_q;
endmodule
`default_nettype wire

// ----- design/greedy_voxel_face_mesher.sv -----
// Top level of the greedy voxel face mesher: controller plus datapath.
// Depends on gvfm_pkg, gvfm_ctrl, gvfm_dp.
//
// channel  | handshake                  | payload
// cell in  | start_i / busy_o           | cell_i (cell_t)
// quad out | quad_valid_o strobe        | quad_o (quad_t)
// config   | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// A cell without last_cell leaves busy_o low, so such beats can follow back to
// back. The last cell starts a scan of the n x n key memory through one
// registered read port: each scan position and each probe to the right or in
// the row below is read, then tested; an edge stops growth without a read;
// each cell of a rectangle is marked, then it is emitted; a flush ends the scan.
// A quad beat shows in the cycle after the next rectangle is emitted, the final
// one in the cycle after the flush; the receiver cannot stall. Config is taken
// only while idle. Reset clears control state and restores merge on, size eight.
`default_nettype none
module greedy_voxel_face_mesher import gvfm_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  cell_t                    cell_i,
  output quad_t                    quad_o,
  output logic                     quad_valid_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  cfg_idx_e                 cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);
  ctl_t ctl;
  sts_t sts;

  // no register change while a slice is being merged
  assign cfg_ready_o = !busy_o;

  gvfm_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i, .last_i(cell_i.last_cell),
    .sts_i(sts), .ctl_o(ctl), .busy_o
  );

  gvfm_dp u_dp (
    .clk_i, .rst_ni, .cell_i, .ctl_i(ctl),
    .cfg_we_i(cfg_valid_i && cfg_ready_o),
    .cfg_idx_i(cfg_index_i), .cfg_data_i,
    .sts_o(sts), .quad_o, .quad_vld_o(quad_valid_o)
  );
endmodule
`default_nettype wire
